// ===== rtl/core/spkt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted pair key table package
// Shared types, codes and constants for the sorted pair key table.
// ----------------------------------------------------------------------------
package spkt_pkg;

	localparam int unsigned DEPTH_DEF = 256;
	localparam int unsigned KEY_W     = 64;
	localparam int unsigned IDX_W     = 8;
	localparam int unsigned TOTAL_W   = 9;
	localparam int unsigned STATUS_W  = 3;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_FOUND    = 3'd0,
		STAT_INSERTED = 3'd1,
		STAT_MISSING  = 3'd2,
		STAT_FULL     = 3'd3,
		STAT_BADIDX   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_INS_MOVE,
		S_INS_PUT,
		S_DEL_MOVE,
		S_RESP
	} state_t;

	typedef struct packed {
		op_t              operation;
		logic [KEY_W-1:0] source_key;
		logic [KEY_W-1:0] target_key;
		logic [IDX_W-1:0] entry_index;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    result_index;
		logic [TOTAL_W-1:0]  entry_total;
	} out_item_t;

	// Target key is the major half, so the packed vector orders as the pair.
	typedef struct packed {
		logic [KEY_W-1:0] target_key;
		logic [KEY_W-1:0] source_key;
	} entry_t;

	typedef struct packed {
		logic    accept;
		logic    srch_issue;
		logic    srch_update;
		logic    mv_start;
		logic    mv_step;
		logic    put_key;
		logic    del_commit;
		logic    clr;
		logic    resp_load;
		status_t status;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic lo_lt_hi;
		logic hit;
		logic full;
		logic bad_idx;
		logic mv_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/core/spkt_ctl.sv =====
// ----------------------------------------------------------------------------
// Sorted pair key table controller
// Sequences the search, shift, commit and response steps of one operation.
// ----------------------------------------------------------------------------
module spkt_ctl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  spkt_pkg::dp_stat_t stat,
	output spkt_pkg::dp_cmd_t  cmd
);
	import spkt_pkg::*;

	state_t  state_q, state_d;
	status_t stat_q, stat_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stat_q  <= STAT_FOUND;
		end else begin
			state_q <= state_d;
			stat_q  <= stat_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_START;
			end
			S_START: begin
				unique case (stat.op)
					OP_LOOKUP, OP_INSERT: state_d = S_SRCH_RD;
					OP_DELETE: state_d = stat.bad_idx ? S_RESP : S_DEL_MOVE;
					OP_CLEAR: state_d = S_RESP;
				endcase
			end
			S_SRCH_RD: begin
				priority if (stat.lo_lt_hi) state_d = S_SRCH_CMP;
				else if (stat.hit || stat.op == OP_LOOKUP || stat.full) state_d = S_RESP;
				else state_d = S_INS_MOVE;
			end
			S_SRCH_CMP: state_d = S_SRCH_RD;
			S_INS_MOVE: begin
				if (stat.mv_done) state_d = S_INS_PUT;
			end
			S_INS_PUT: state_d = S_RESP;
			S_DEL_MOVE: begin
				if (stat.mv_done) state_d = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		stat_d   = stat_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			S_START: begin
				unique case (stat.op)
					OP_LOOKUP, OP_INSERT: ;
					OP_DELETE: begin
						if (stat.bad_idx) stat_d = STAT_BADIDX;
						else cmd.mv_start = 1'b1;
					end
					OP_CLEAR: begin
						cmd.clr = 1'b1;
						stat_d  = STAT_FOUND;
					end
				endcase
			end
			S_SRCH_RD: begin
				priority if (stat.lo_lt_hi) cmd.srch_issue = 1'b1;
				else if (stat.hit) stat_d = STAT_FOUND;
				else if (stat.op == OP_LOOKUP) stat_d = STAT_MISSING;
				else if (stat.full) stat_d = STAT_FULL;
				else cmd.mv_start = 1'b1;
			end
			S_SRCH_CMP: cmd.srch_update = 1'b1;
			S_INS_MOVE: cmd.mv_step = !stat.mv_done;
			S_INS_PUT: begin
				cmd.put_key = 1'b1;
				stat_d      = STAT_INSERTED;
			end
			S_DEL_MOVE: begin
				if (stat.mv_done) begin
					cmd.del_commit = 1'b1;
					stat_d         = STAT_FOUND;
				end else begin
					cmd.mv_step = 1'b1;
				end
			end
			S_RESP: cmd.resp_load = stat.out_free;
			default: ;
		endcase
		cmd.status = stat_q;
	end

endmodule

// ===== rtl/core/spkt_dp.sv =====
// ----------------------------------------------------------------------------
// Sorted pair key table datapath
// Key memory, search bounds, entry shifter, entry count and result register.
// ----------------------------------------------------------------------------
module spkt_dp #(
	parameter int unsigned DEPTH = spkt_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  spkt_pkg::in_item_t  in_data,
	input  spkt_pkg::dp_cmd_t   cmd,
	output spkt_pkg::dp_stat_t  stat,
	output logic                out_valid,
	input  logic                out_ready,
	output spkt_pkg::out_item_t out_data
);
	import spkt_pkg::*;

	localparam int unsigned AW   = $clog2(DEPTH);
	localparam int unsigned CW   = $clog2(DEPTH + 1);
	localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;

	entry_t           mem [DEPTH];
	entry_t           rdata_q;
	entry_t           key_q;
	op_t              op_q;
	logic [IDX_W-1:0] idx_q;
	logic [CW-1:0]    count_q, lo_q, hi_q, ptr_q, mid;
	logic [AW-1:0]    mid_s1, dst_s1;
	logic             hit_q, pend_s1;
	logic             ins_mode, mv_rd, re, we, ent_lt, ent_eq;
	logic [AW-1:0]    raddr, waddr;
	entry_t           wdata;
	logic [IDX_W-1:0] res_idx;
	out_item_t        out_q;
	logic             out_vld_q;

	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign ins_mode = (op_q == OP_INSERT);
	assign mv_rd    = ins_mode ? (ptr_q > lo_q) : (ptr_q < count_q);
	assign ent_lt   = rdata_q < key_q;
	assign ent_eq   = rdata_q == key_q;

	always_comb begin
		re    = cmd.srch_issue || (cmd.mv_step && mv_rd);
		raddr = ins_mode ? AW'(ptr_q - CW'(1)) : AW'(ptr_q);
		if (cmd.srch_issue) raddr = AW'(mid);
		we    = (cmd.mv_step && pend_s1) || cmd.put_key;
		waddr = cmd.put_key ? AW'(lo_q) : dst_s1;
		wdata = cmd.put_key ? key_q : rdata_q;
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q.target_key <= in_data.target_key;
			key_q.source_key <= in_data.source_key;
			idx_q            <= in_data.entry_index;
		end
		if (cmd.srch_issue) mid_s1 <= AW'(mid);
		if (cmd.mv_step && mv_rd) dst_s1 <= ins_mode ? AW'(ptr_q) : AW'(ptr_q - CW'(1));
		if (cmd.resp_load) begin
			out_q.status       <= cmd.status;
			out_q.result_index <= res_idx;
			out_q.entry_total  <= TOTAL_W'(count_q);
		end
	end

	always_comb begin
		unique case (op_q)
			OP_LOOKUP, OP_INSERT: res_idx = IDX_W'(lo_q);
			OP_DELETE: res_idx = idx_q;
			OP_CLEAR: res_idx = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q      <= OP_LOOKUP;
			count_q   <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			hit_q     <= 1'b0;
			ptr_q     <= '0;
			pend_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				op_q  <= in_data.operation;
				lo_q  <= '0;
				hi_q  <= count_q;
				hit_q <= 1'b0;
			end
			if (cmd.srch_update) begin
				if (ent_lt) begin
					lo_q <= CW'(mid_s1) + CW'(1);
				end else begin
					hi_q  <= CW'(mid_s1);
					hit_q <= ent_eq;
				end
			end
			if (cmd.mv_start) begin
				ptr_q   <= ins_mode ? count_q : CW'(idx_q) + CW'(1);
				pend_s1 <= 1'b0;
			end else if (cmd.mv_step) begin
				pend_s1 <= mv_rd;
				if (mv_rd) ptr_q <= ins_mode ? ptr_q - CW'(1) : ptr_q + CW'(1);
			end
			priority if (cmd.clr) count_q <= '0;
			else if (cmd.put_key) count_q <= count_q + CW'(1);
			else if (cmd.del_commit) count_q <= count_q - CW'(1);
			if (cmd.resp_load) out_vld_q <= 1'b1;
			else if (out_ready) out_vld_q <= 1'b0;
		end
	end

	always_comb begin
		stat.op       = op_q;
		stat.lo_lt_hi = lo_q < hi_q;
		stat.hit      = hit_q;
		stat.full     = count_q == CW'(DEPTH);
		stat.bad_idx  = CMPW'(idx_q) >= CMPW'(count_q);
		stat.mv_done  = !pend_s1 && !mv_rd;
		stat.out_free = !out_vld_q || out_ready;
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above table depth");

	a_bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		lo_q <= hi_q)
		else $error("search bounds crossed");

	a_put_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put_key |-> !pend_s1)
		else $error("key write collides with a pending shift write");

	a_update_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.srch_update |-> $past(cmd.srch_issue))
		else $error("search compare without a preceding read");

	a_resp_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resp_load |-> (!out_vld_q || out_ready))
		else $error("result register overwritten");

endmodule

// ===== rtl/core/sorted_pair_key_table.sv =====
// ----------------------------------------------------------------------------
// Sorted pair key table
// Up to DEPTH unique (target, source) pairs in sorted order with lookup,
// lookup-or-insert, delete at index and clear.
//
// Channel  Direction  Beat
// in       input      operation, source_key, target_key, entry_index
// out      output     status, result_index, entry_total
//
// One operation at a time; a lookup runs a binary search over the n stored
// entries, each halving step a read (S_SRCH_RD) then a compare (S_SRCH_CMP).
// An insert then shifts the entries from its position p up by one, and a
// delete shifts those above entry_index down by one; the single key memory
// read port moves one entry a cycle. The result register lets a new beat in
// while the last result waits. Reset clears the count and the control
// registers but not the key memory; there is no memory clearing pass.
// ----------------------------------------------------------------------------
module sorted_pair_key_table #(
	parameter int unsigned DEPTH = spkt_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  spkt_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output spkt_pkg::out_item_t out_data
);
	import spkt_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	spkt_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	spkt_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Sorted pair key table testbench
// Drives lookup, lookup-or-insert, delete and clear beats into the table and
// checks every result beat against a mirror of the sorted key store that is
// updated as each input beat is accepted. A directed opening is followed by
// three phases that each fill the table, probe it while full and then churn
// it, each with its own pattern of idle cycles on the two channels.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spkt_pkg::*;

	localparam int          CLK_PERIOD  = 10;
	localparam int          TABLE_DEPTH = DEPTH_DEF;
	localparam int          QUIET_LIMIT = 5000;
	localparam int          DRAIN_WAIT  = 300;
	localparam logic [KEY_W-1:0] KEY_MAX = '1;

	class pair_table_mirror;
		entry_t    pairs[TABLE_DEPTH];
		int        held;
		out_item_t awaited[$];
		int        errors;
		int        beats;
		int        fills;
		int        tally[8];

		function int lower_bound(entry_t probe);
			int lo;
			int hi;
			int mid;
			lo = 0;
			hi = held;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (pairs[mid] < probe) begin
					lo = mid + 1;
				end else begin
					hi = mid;
				end
			end
			return lo;
		endfunction

		function entry_t pick_stored();
			return pairs[$urandom_range(0, held - 1)];
		endfunction

		function void apply_op(in_item_t beat);
			entry_t    probe;
			int        pos;
			status_t   st;
			out_item_t want;
			probe = entry_t'({beat.target_key, beat.source_key});
			pos = 0;
			st = STAT_FOUND;
			case (beat.operation)
				OP_LOOKUP, OP_INSERT: begin
					pos = lower_bound(probe);
					if (pos < held && pairs[pos] == probe) begin
						st = STAT_FOUND;
					end else if (beat.operation == OP_LOOKUP) begin
						st = STAT_MISSING;
					end else if (held >= TABLE_DEPTH) begin
						st = STAT_FULL;
					end else begin
						for (int k = held; k > pos; k--) begin
							pairs[k] = pairs[k - 1];
						end
						pairs[pos] = probe;
						held++;
						st = STAT_INSERTED;
						if (held == TABLE_DEPTH) begin
							fills++;
						end
					end
				end
				OP_DELETE: begin
					pos = int'(beat.entry_index);
					if (pos >= held) begin
						st = STAT_BADIDX;
					end else begin
						for (int k = pos; k < held - 1; k++) begin
							pairs[k] = pairs[k + 1];
						end
						held--;
						st = STAT_FOUND;
					end
				end
				default: begin
					held = 0;
					pos = 0;
					st = STAT_FOUND;
				end
			endcase
			want.status = st;
			want.result_index = IDX_W'(pos);
			want.entry_total = TOTAL_W'(held);
			awaited.push_back(want);
			tally[st]++;
			beats++;
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (awaited.size() == 0) begin
				$error("Unexpected result beat: status %0d, index %0d, total %0d.",
					got.status, got.result_index, got.entry_total);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.result_index !== want.result_index) begin
				$error("result_index: expected %0d, got %0d",
					want.result_index, got.result_index);
				errors++;
			end
			if (got.entry_total !== want.entry_total) begin
				$error("entry_total: expected %0d, got %0d",
					want.entry_total, got.entry_total);
				errors++;
			end
		endfunction
	endclass

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	int unsigned      send_idle_pct = 0;
	int unsigned      recv_idle_pct = 0;
	int               quiet_cycles  = 0;
	int               directed_beats;
	pair_table_mirror mirror;

	sorted_pair_key_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		out_ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			mirror.check_result(out_data);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("Timeout: no beat accepted for %0d cycles.", QUIET_LIMIT);
				$display("FAIL sorted_pair_key_table");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic logic [KEY_W-1:0] rand_key();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return KEY_MAX;
			2, 3: return KEY_W'($urandom_range(0, 15));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic entry_t rand_pair();
		return entry_t'({rand_key(), rand_key()});
	endfunction

	function automatic entry_t wide_pair();
		return entry_t'({$urandom, $urandom, $urandom, $urandom});
	endfunction

	function automatic in_item_t key_beat(op_t op, entry_t pair);
		in_item_t beat;
		beat.operation = op;
		beat.source_key = pair.source_key;
		beat.target_key = pair.target_key;
		beat.entry_index = IDX_W'($urandom);
		return beat;
	endfunction

	function automatic in_item_t index_beat(op_t op, int idx);
		in_item_t beat;
		beat.operation = op;
		beat.source_key = {$urandom, $urandom};
		beat.target_key = {$urandom, $urandom};
		beat.entry_index = IDX_W'(idx);
		return beat;
	endfunction

	task automatic send_beat(in_item_t beat);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		do @(posedge clk); while (!in_ready);
		mirror.apply_op(beat);
	endtask

	task automatic run_phase(int unsigned send_pct, int unsigned recv_pct, int churn_beats);
		int burst_left;
		bit shrink;
		int roll;
		int ins_w;
		int del_w;
		entry_t pair;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		send_beat(index_beat(OP_CLEAR, $urandom_range(0, 255)));
		while (mirror.held < TABLE_DEPTH) begin
			if (mirror.held > 0 && $urandom_range(0, 9) == 0) begin
				send_beat(key_beat(OP_LOOKUP, mirror.pick_stored()));
			end else begin
				send_beat(key_beat(OP_INSERT, wide_pair()));
			end
		end
		send_beat(key_beat(OP_INSERT, entry_t'({KEY_MAX, KEY_MAX})));
		send_beat(key_beat(OP_LOOKUP, entry_t'({KEY_MAX, KEY_MAX})));
		send_beat(key_beat(OP_INSERT, entry_t'('0)));
		send_beat(key_beat(OP_INSERT, mirror.pick_stored()));
		repeat (4) send_beat(key_beat(OP_INSERT, wide_pair()));
		send_beat(index_beat(OP_DELETE, TABLE_DEPTH - 1));
		burst_left = 0;
		shrink = 1'b0;
		repeat (churn_beats) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(20, 60);
				shrink = !shrink;
			end
			burst_left--;
			roll = $urandom_range(0, 99);
			ins_w = shrink ? 15 : 50;
			del_w = shrink ? 50 : 15;
			if (mirror.held > 0 && $urandom_range(0, 99) < 40) begin
				pair = mirror.pick_stored();
			end else begin
				pair = rand_pair();
			end
			if (roll == 99) begin
				send_beat(index_beat(OP_CLEAR, $urandom_range(0, 255)));
			end else if (roll < ins_w) begin
				send_beat(key_beat(OP_INSERT, pair));
			end else if (roll < ins_w + del_w) begin
				if (mirror.held > 0 && $urandom_range(0, 9) != 0) begin
					send_beat(index_beat(OP_DELETE, $urandom_range(0, mirror.held - 1)));
				end else begin
					send_beat(index_beat(OP_DELETE, $urandom_range(0, 255)));
				end
			end else begin
				send_beat(key_beat(OP_LOOKUP, pair));
			end
		end
	endtask

	initial begin
		mirror = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(index_beat(OP_CLEAR, 255));
		send_beat(key_beat(OP_LOOKUP, entry_t'('0)));
		send_beat(index_beat(OP_DELETE, 0));
		send_beat(key_beat(OP_INSERT, entry_t'('0)));
		send_beat(key_beat(OP_INSERT, entry_t'({KEY_MAX, KEY_MAX})));
		send_beat(key_beat(OP_INSERT, entry_t'({KEY_W'(0), KEY_MAX})));
		send_beat(key_beat(OP_INSERT, entry_t'({KEY_MAX, KEY_W'(0)})));
		send_beat(key_beat(OP_INSERT, entry_t'({KEY_W'(5), KEY_W'(5)})));
		send_beat(key_beat(OP_INSERT, entry_t'('0)));
		send_beat(key_beat(OP_LOOKUP, entry_t'({KEY_MAX, KEY_MAX})));
		send_beat(key_beat(OP_LOOKUP, entry_t'({KEY_MAX, KEY_W'(1)})));
		send_beat(key_beat(OP_LOOKUP, entry_t'({KEY_W'(0), KEY_W'(7)})));
		send_beat(index_beat(OP_DELETE, 255));
		send_beat(index_beat(OP_DELETE, 5));
		send_beat(index_beat(OP_DELETE, 4));
		send_beat(index_beat(OP_DELETE, 0));
		send_beat(index_beat(OP_DELETE, 1));
		send_beat(key_beat(OP_LOOKUP, entry_t'({KEY_W'(5), KEY_W'(5)})));
		send_beat(index_beat(OP_CLEAR, 0));
		send_beat(key_beat(OP_LOOKUP, entry_t'({KEY_W'(5), KEY_W'(5)})));
		send_beat(key_beat(OP_INSERT, rand_pair()));
		directed_beats = mirror.beats;

		run_phase(35, 62, 220);
		run_phase(62, 35, 220);
		run_phase(0, 0, 220);

		in_valid <= 1'b0;
		while (mirror.awaited.size() > 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Ran %0d operations, %0d of them directed: %0d found or done, %0d inserted,",
			mirror.beats, directed_beats, mirror.tally[STAT_FOUND],
			mirror.tally[STAT_INSERTED]);
		$display("%0d missing, %0d rejected as full, %0d bad index; table filled %0d times.",
			mirror.tally[STAT_MISSING], mirror.tally[STAT_FULL],
			mirror.tally[STAT_BADIDX], mirror.fills);
		if (mirror.errors == 0) begin
			$display("PASS sorted_pair_key_table");
		end else begin
			$display("FAIL sorted_pair_key_table");
		end
		$finish;
	end

endmodule

// ===== sorted_pair_key_table.f =====
rtl/core/spkt_pkg.sv
rtl/core/spkt_ctl.sv
rtl/core/spkt_dp.sv
rtl/core/sorted_pair_key_table.sv
test/tb.sv
